[hdl/b64d_pkg.sv]
package b64d_pkg;

    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0   = 8'h30;
    localparam logic [7:0] CH_DIGIT_9   = 8'h39;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_UNDERLINE = 8'h5F;
    localparam logic [7:0] CH_PAD       = 8'h3D;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam logic [5:0] OFS_LOWER = 6'd26;
    localparam logic [5:0] OFS_DIGIT = 6'd52;
    localparam logic [5:0] VAL_62    = 6'd62;
    localparam logic [5:0] VAL_63    = 6'd63;

    localparam int unsigned SLOT_COUNT = 3;
    localparam int unsigned PAD_BIT    = 6;

    localparam logic REG_ALPHABET_SELECT = 1'b0;

    typedef logic [6:0] slot_t;
    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic            load;
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
    } group_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] value;
    } sextet_t;

    function automatic sextet_t lookup_sextet(input logic [7:0] ch, input logic url);
        sextet_t    res;
        logic [7:0] diff;
        res  = '{hit: 1'b0, value: 6'd0};
        diff = 8'd0;
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z)
        begin
            diff = ch - CH_UPPER_A;
            res  = '{hit: 1'b1, value: diff[5:0]};
        end
        else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
        begin
            diff = ch - CH_LOWER_A;
            res  = '{hit: 1'b1, value: diff[5:0] + OFS_LOWER};
        end
        else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9)
        begin
            diff = ch - CH_DIGIT_0;
            res  = '{hit: 1'b1, value: diff[5:0] + OFS_DIGIT};
        end
        else if (url)
        begin
            if (ch == CH_MINUS)
                res = '{hit: 1'b1, value: VAL_62};
            else if (ch == CH_UNDERLINE)
                res = '{hit: 1'b1, value: VAL_63};
        end
        else
        begin
            if (ch == CH_PLUS)
                res = '{hit: 1'b1, value: VAL_62};
            else if (ch == CH_SLASH)
                res = '{hit: 1'b1, value: VAL_63};
        end
        return res;
    endfunction

endpackage

[hdl/b64d_if.sv]
interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;

    modport source (output valid, output in_char, input ready);
    modport sink (input valid, input in_char, output ready);
endinterface

interface b64d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

[hdl/b64d_slots.sv]
module b64d_slots (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              alphabet_select,
    input  logic              emit_free,
    b64d_char_if.sink         enc,
    output b64d_pkg::group_t  group
);
    import b64d_pkg::*;

    logic       char_valid_reg, char_valid_next;
    byte_t      char_reg, char_next;
    slot_t      slot_reg [SLOT_COUNT];
    logic [1:0] fill_reg, fill_next;

    sextet_t    sx;
    logic       is_slot;
    slot_t      slot_val;
    logic       complete;
    logic       take;
    logic       e0, e1, e2;
    byte_t      b0, b1, b2;
    slot_t      s0, s1, s2, s3;

    always_comb
    begin
        sx       = lookup_sextet(char_reg, alphabet_select);
        is_slot  = 1'b0;
        slot_val = '0;
        if (char_reg == CH_NEWLINE || char_reg == CH_RETURN || char_reg == CH_SPACE)
            is_slot = 1'b0;
        else if (char_reg == CH_PAD)
        begin
            is_slot  = 1'b1;
            slot_val = 7'h40;
        end
        else if (sx.hit)
        begin
            is_slot  = 1'b1;
            slot_val = {1'b0, sx.value};
        end
    end

    assign complete  = char_valid_reg && is_slot && (fill_reg == 2'd3);
    assign take      = char_valid_reg && (!complete || emit_free);
    assign enc.ready = !char_valid_reg || take;

    always_comb
    begin
        char_valid_next = char_valid_reg;
        char_next       = char_reg;
        if (enc.valid && enc.ready)
        begin
            char_valid_next = 1'b1;
            char_next       = enc.in_char;
        end
        else if (take)
            char_valid_next = 1'b0;
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (take && is_slot)
            fill_next = fill_reg + 2'd1;
    end

    assign s0 = slot_reg[0];
    assign s1 = slot_reg[1];
    assign s2 = slot_reg[2];
    assign s3 = slot_val;

    assign e0 = !s0[PAD_BIT] && !s1[PAD_BIT];
    assign e1 = !s2[PAD_BIT] && !s1[PAD_BIT];
    assign e2 = !s3[PAD_BIT] && !s2[PAD_BIT];
    assign b0 = {s0[5:0], s1[5:4]};
    assign b1 = {s1[3:0], s2[5:2]};
    assign b2 = {s2[1:0], s3[5:0]};

    // pack the emitted bytes to the front of the run
    always_comb
    begin
        group.load     = take && complete;
        group.count    = {1'b0, e0} + {1'b0, e1} + {1'b0, e2};
        group.bytes[0] = e0 ? b0 : (e1 ? b1 : b2);
        group.bytes[1] = (e0 && e1) ? b1 : b2;
        group.bytes[2] = b2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
            fill_reg       <= 2'd0;
            for (int i = 0; i < SLOT_COUNT; i++)
                slot_reg[i] <= '0;
        end
        else
        begin
            char_valid_reg <= char_valid_next;
            fill_reg       <= fill_next;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (take && is_slot && fill_reg == 2'(i))
                    slot_reg[i] <= slot_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

endmodule

[hdl/b64d_emit.sv]
module b64d_emit (
    input  logic             clk,
    input  logic             rst_n,
    input  b64d_pkg::group_t group,
    output logic             emit_free,
    b64d_byte_if.source      dec
);
    import b64d_pkg::*;

    logic [1:0] count_reg, count_next;
    byte_t      q_reg [3];
    byte_t      q_next [3];
    logic       fire;

    assign fire            = dec.valid && dec.ready;
    assign emit_free       = (count_reg == 2'd0) || (count_reg == 2'd1 && fire);
    assign dec.valid       = count_reg != 2'd0;
    assign dec.out_byte    = q_reg[0];
    assign dec.last_of_run = count_reg == 2'd1;

    always_comb
    begin
        count_next = count_reg;
        q_next     = q_reg;
        if (group.load)
        begin
            count_next = group.count;
            q_next[0]  = group.bytes[0];
            q_next[1]  = group.bytes[1];
            q_next[2]  = group.bytes[2];
        end
        else if (fire)
        begin
            count_next = count_reg - 2'd1;
            q_next[0]  = q_reg[1];
            q_next[1]  = q_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

[hdl/base64_decoder.sv]
// Base64 decoder: one character per enc transaction, decoded bytes on dec, one byte per
// transaction with last_of_run marking the final byte of each group. A character is
// taken every cycle; a group of four slots gives up to three bytes, drained one per
// cycle while dec.ready is high from a three-entry run queue, so the input stalls only
// when a group completes while the previous run is still queued.
// Register 0 (address 0, bit 0) selects the standard (0) or URL-safe (1) alphabet.
module base64_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    b64d_char_if.sink   enc,
    b64d_byte_if.source dec
);
    import b64d_pkg::*;

    logic   alphabet_reg, alphabet_next;
    logic   emit_free;
    group_t group;

    assign pready = 1'b1;

    always_comb
    begin
        alphabet_next = alphabet_reg;
        if (psel && penable && pwrite && pready && paddr[2] == REG_ALPHABET_SELECT)
            alphabet_next = pwdata[0];
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == REG_ALPHABET_SELECT)
            prdata = {31'd0, alphabet_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            alphabet_reg <= 1'b0;
        else
            alphabet_reg <= alphabet_next;
    end

    b64d_slots u_slots (
        .clk             (clk),
        .rst_n           (rst_n),
        .alphabet_select (alphabet_reg),
        .emit_free       (emit_free),
        .enc             (enc),
        .group           (group)
    );

    b64d_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .group     (group),
        .emit_free (emit_free),
        .dec       (dec)
    );

endmodule

[dv/b64d_checker.sv]
module b64d_checker #(
    parameter logic [2:0] ALPHABET_ADDR = 3'd0
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    b64d_char_if        enc,
    b64d_byte_if        dec,
    output int          error_count,
    output int          bytes_pending,
    output int          chars_seen,
    output int          bytes_checked
);
    import b64d_pkg::*;

    typedef struct packed {
        byte_t data;
        logic  last;
    } decoded_t;

    decoded_t   decoded_q[$];
    logic       url_mode;
    slot_t      slots[SLOT_COUNT];
    logic [1:0] filled;

    function automatic logic char_to_slot(input byte_t ch, input logic url, output slot_t slot);
        slot = '0;
        if (ch == CH_PAD)
            slot[PAD_BIT] = 1'b1;
        else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z)
            slot = {1'b0, 6'(ch - CH_UPPER_A)};
        else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
            slot = {1'b0, 6'(ch - CH_LOWER_A) + OFS_LOWER};
        else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9)
            slot = {1'b0, 6'(ch - CH_DIGIT_0) + OFS_DIGIT};
        else if (ch == (url ? CH_MINUS : CH_PLUS))
            slot = {1'b0, VAL_62};
        else if (ch == (url ? CH_UNDERLINE : CH_SLASH))
            slot = {1'b0, VAL_63};
        else
            return 1'b0;
        return 1'b1;
    endfunction

    task automatic decode_char(input byte_t ch);
        slot_t cur;
        slot_t s0;
        slot_t s1;
        slot_t s2;
        byte_t group_bytes[$];
        if (!char_to_slot(ch, url_mode, cur))
            return;
        if (filled != 2'd3)
        begin
            slots[filled] = cur;
            filled = filled + 2'd1;
            return;
        end
        s0 = slots[0];
        s1 = slots[1];
        s2 = slots[2];
        filled = 2'd0;
        if (!s0[PAD_BIT] && !s1[PAD_BIT])
            group_bytes.push_back({s0[5:0], s1[5:4]});
        if (!s1[PAD_BIT] && !s2[PAD_BIT])
            group_bytes.push_back({s1[3:0], s2[5:2]});
        if (!s2[PAD_BIT] && !cur[PAD_BIT])
            group_bytes.push_back({s2[1:0], cur[5:0]});
        foreach (group_bytes[k])
            decoded_q.push_back('{data: group_bytes[k], last: k == group_bytes.size() - 1});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        decoded_t want;
        if (!rst_n)
        begin
            url_mode      = 1'b0;
            filled        = 2'd0;
            slots         = '{default: '0};
            decoded_q.delete();
            error_count   = 0;
            bytes_pending = 0;
            chars_seen    = 0;
            bytes_checked = 0;
        end
        else
        begin
            if (psel && penable && pready && paddr == ALPHABET_ADDR)
            begin
                if (pwrite)
                    url_mode = pwdata[0];
                else if (prdata !== {31'd0, url_mode})
                begin
                    $display("%0t: register read expected %08h, got %08h",
                             $time, {31'd0, url_mode}, prdata);
                    error_count++;
                end
            end
            if (enc.valid && enc.ready)
            begin
                chars_seen++;
                decode_char(enc.in_char);
            end
            if (dec.valid && dec.ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $display("%0t: unexpected byte, expected none, got %02h last %0b",
                             $time, dec.out_byte, dec.last_of_run);
                    error_count++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    bytes_checked++;
                    if (dec.out_byte !== want.data)
                    begin
                        $display("%0t: out_byte expected %02h, got %02h",
                                 $time, want.data, dec.out_byte);
                        error_count++;
                    end
                    if (dec.last_of_run !== want.last)
                    begin
                        $display("%0t: last_of_run expected %0b, got %0b",
                                 $time, want.last, dec.last_of_run);
                        error_count++;
                    end
                end
            end
            bytes_pending = decoded_q.size();
        end
    end

endmodule

[dv/testbench.sv]
module testbench;
    import b64d_pkg::*;

    localparam logic [2:0] ALPHABET_ADDR = 3'(4 * REG_ALPHABET_SELECT);
    localparam logic [2:0] SPARE_ADDR    = ALPHABET_ADDR + 3'd4;
    localparam int         CYCLE_LIMIT   = 100000;
    localparam int         RANDOM_SLOTS  = 120;
    localparam int         PHASES        = 4;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         LONG_HOLD     = 150;

    typedef enum int {RX_FLOW, RX_COIN, RX_EVERY_THIRD, RX_SPARSE} rx_mode_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int   error_count;
    int   bytes_pending;
    int   chars_seen;
    int   bytes_checked;
    int   cycle_count = 0;
    int   hold_request;
    int   burst_left;
    int   slots_sent;
    logic url_sel;

    b64d_char_if enc();
    b64d_byte_if dec();

    base64_decoder i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .enc     (enc),
        .dec     (dec)
    );

    b64d_checker #(
        .ALPHABET_ADDR (ALPHABET_ADDR)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .enc           (enc),
        .dec           (dec),
        .error_count   (error_count),
        .bytes_pending (bytes_pending),
        .chars_seen    (chars_seen),
        .bytes_checked (bytes_checked)
    );

    initial
        clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rx_mode_t mode;
        int       mode_left;
        int       hold_len;
        dec.ready = 1'b0;
        mode      = RX_FLOW;
        mode_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_len     = hold_request;
                hold_request = 0;
                dec.ready   <= 1'b0;
                repeat (hold_len) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
                RX_FLOW:        dec.ready <= 1'b1;
                RX_COIN:        dec.ready <= 1'($urandom_range(0, 1));
                RX_EVERY_THIRD: dec.ready <= (mode_left % 3 == 0);
                default:        dec.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic byte_t sextet_char(input logic [5:0] v, input logic url);
        if (v < OFS_LOWER)
            return CH_UPPER_A + 8'(v);
        if (v < OFS_DIGIT)
            return CH_LOWER_A + 8'(v - OFS_LOWER);
        if (v < VAL_62)
            return CH_DIGIT_0 + 8'(v - OFS_DIGIT);
        if (v == VAL_62)
            return url ? CH_MINUS : CH_PLUS;
        return url ? CH_UNDERLINE : CH_SLASH;
    endfunction

    function automatic byte_t noise_char(input logic url);
        case ($urandom_range(0, 6))
            0:       return CH_NEWLINE;
            1:       return CH_RETURN;
            2:       return CH_SPACE;
            3:       return url ? CH_PLUS : CH_MINUS;
            4:       return url ? CH_SLASH : CH_UNDERLINE;
            5:       return 8'($urandom_range(128, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_char(input byte_t ch);
        int gap_len;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
            gap_len    = $urandom_range(0, 5);
            if (gap_len > 0)
            begin
                enc.valid <= 1'b0;
                repeat (gap_len) @(posedge clk);
            end
        end
        burst_left--;
        enc.valid   <= 1'b1;
        enc.in_char <= ch;
        @(negedge clk);
        while (!enc.ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic send_text(input string text);
        foreach (text[i])
            send_char(byte_t'(text[i]));
    endtask

    // hold the input off until every decoded byte has drained
    task automatic drain();
        enc.valid <= 1'b0;
        burst_left = 0;
        do
            @(negedge clk);
        while (bytes_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic select_alphabet(input logic url);
        url_sel = url;
        reg_access(1'b1, ALPHABET_ADDR, {31'd0, url});
    endtask

    task automatic send_group();
        int         shape;
        int         keep;
        int         k;
        logic [3:0] is_pad;
        shape = $urandom_range(0, 9);
        keep  = ($urandom_range(0, 24) == 0) ? $urandom_range(1, 3) : 4;
        if (shape < 7)
            is_pad = 4'b0000;
        else if (shape == 7)
            is_pad = 4'b1100;
        else if (shape == 8)
            is_pad = 4'b1000;
        else
            is_pad = 4'($urandom);
        for (k = 0; k < keep; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_char(noise_char(url_sel));
            send_char(is_pad[k] ? CH_PAD : sextet_char(6'($urandom), url_sel));
            slots_sent++;
        end
    endtask

    initial
    begin
        int phase;
        int phase_slots;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        enc.valid    = 1'b0;
        enc.in_char  = '0;
        hold_request = 0;
        burst_left   = 0;
        slots_sent   = 0;
        url_sel      = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("AZaz09+/\n\r ");
        send_char(8'h00);
        send_char(8'hFF);
        send_char(CH_MINUS);
        send_text("=A==A=B=QUJ=QU");

        // switch alphabets with half a group held in the slots
        drain();
        reg_access(1'b1, SPARE_ADDR, 32'd1);
        reg_access(1'b1, ALPHABET_ADDR, 32'hFFFF_FFFE);
        reg_access(1'b0, ALPHABET_ADDR, 32'd0);
        select_alphabet(1'b1);
        reg_access(1'b0, ALPHABET_ADDR, 32'd0);
        send_text("-_");

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain();
            select_alphabet(phase[0]);
            phase_slots = slots_sent;
            if (phase == 1)
                hold_request = LONG_HOLD;
            while (slots_sent - phase_slots < RANDOM_SLOTS / PHASES)
            begin
                send_group();
                if (phase == 2 && slots_sent - phase_slots >= RANDOM_SLOTS / (2 * PHASES)
                    && slots_sent - phase_slots < RANDOM_SLOTS / (2 * PHASES) + 4)
                    drain();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d characters on both alphabets, %0d decoded bytes checked.",
                 chars_seen, bytes_checked);
        $display("Padding, whitespace, out-of-alphabet bytes and a long output stall included.");
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[base64_decoder.f]
hdl/b64d_pkg.sv
hdl/b64d_if.sv
hdl/b64d_slots.sv
hdl/b64d_emit.sv
hdl/base64_decoder.sv
dv/b64d_checker.sv
dv/testbench.sv
